### rtl/sbpf_pkg.sv
// Shared constants, types and the CRC byte function of the servo-bus packet framer.
`default_nettype none

package sbpf_pkg;

    localparam int unsigned COUNT_W = 11;
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam logic [COUNT_W-1:0] MAX_PARAMS   = 11'd1024;
    localparam logic [COUNT_W-1:0] LEN_OVERHEAD = 11'd3;
    localparam logic [15:0]        CRC_POLY     = 16'h8005;

    localparam logic [7:0] HDR_SYNC     = 8'hFF;
    localparam logic [7:0] HDR_MARK     = 8'hFD;
    localparam logic [7:0] HDR_RESERVED = 8'h00;

    // Output byte positions within one input item.
    localparam logic [STEP_W-1:0] STEP_FIRST    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_INSTR    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_HDR_CRCL = 4'd8;
    localparam logic [STEP_W-1:0] STEP_HDR_CRCH = 4'd9;
    localparam logic [STEP_W-1:0] STEP_PRM_CRCL = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PRM_CRCH = 4'd2;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_PARAM = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        HDR_SYNC0 = 3'd0,
        HDR_SYNC1 = 3'd1,
        HDR_MARKB = 3'd2,
        HDR_RSVD  = 3'd3,
        HDR_ID    = 3'd4,
        HDR_LENL  = 3'd5,
        HDR_LENH  = 3'd6,
        HDR_INSTR = 3'd7
    } hdr_pos_t;

    // One byte of CRC-16, polynomial 0x8005, MSB first, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/servo_bus_packet_framer.sv
// Servo-bus instruction packet framer: input item register, byte sequencer and output register.
//
// Input stream (s_*): s_tuser selects the item kind, 0 opens a packet with device_id,
// instruction_code and param_count, 1 carries one parameter byte. Output stream (m_*):
// one packet byte per transfer, m_tlast on the final byte caused by an input item,
// m_tuser flags the CRC high byte that closes a packet and out-of-order items.
// A start item yields the header FF FF FD 00, id, length low/high and instruction,
// plus the two CRC bytes when the count is zero. A parameter item yields its byte,
// plus the two CRC bytes when it is the last one expected. A parameter with no
// packet open yields a single zero byte with the error flag.
// The input item is registered, and its bytes reach m_* through the output register.
// Throughput: one output byte per cycle while the receiver is ready; an item holds the
// sequencer until its output bytes (1 to 10) are out, and the next item is accepted in the
// cycle its last byte moves to the output register, so parameter items stream at one per
// cycle while unstalled. The CRC of each byte is formed in one pass of an 8-step shift chain.
// Reset (aresetn low, synchronous) closes any packet and empties both registers.
// When the receiver stalls the output register holds its byte; the sequencer stops,
// and one further input item may still be taken into the input register.
`default_nettype none

module servo_bus_packet_framer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] device_id, [15:8] instruction_code, [26:16] param_count,
    // [34:27] param_byte, [39:35] zero
    input  wire logic [sbpf_pkg::IN_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] tx_byte
    output logic [sbpf_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic             m_tlast,
    // [0] packet_end, [1] protocol_error
    output logic [1:0]       m_tuser
);

    // Input item register.
    logic                          item_valid_reg;
    sbpf_pkg::mode_t               item_mode_reg;
    logic [7:0]                    item_id_reg;
    logic [7:0]                    item_instr_reg;
    logic [sbpf_pkg::COUNT_W-1:0]  item_count_reg;
    logic [7:0]                    item_param_reg;

    // Sequencer and packet state.
    logic [sbpf_pkg::STEP_W-1:0]   step_reg;
    logic                          packet_open_reg;
    logic [sbpf_pkg::COUNT_W-1:0]  remaining_reg;
    logic [15:0]                   crc_reg;

    // Output register.
    logic                          m_tvalid_reg;
    logic [7:0]                    m_tdata_reg;
    logic                          m_tlast_reg;
    logic [1:0]                    m_tuser_reg;

    logic                          s_accept;
    logic                          out_load;
    logic [sbpf_pkg::COUNT_W-1:0]  sat_count;
    logic [sbpf_pkg::COUNT_W-1:0]  pkt_len;
    logic [sbpf_pkg::COUNT_W-1:0]  remaining_dec;
    logic                          orphan;
    logic                          is_data;
    logic                          is_crc_hi;
    logic                          open_now;
    logic [7:0]                    byte_val;
    logic                          byte_last;
    logic                          byte_end;
    logic                          byte_err;
    logic [15:0]                   crc_base;
    logic [15:0]                   crc_upd;

    assign sat_count = (item_count_reg > sbpf_pkg::MAX_PARAMS) ? sbpf_pkg::MAX_PARAMS
                                                               : item_count_reg;
    assign pkt_len       = sat_count + sbpf_pkg::LEN_OVERHEAD;
    assign remaining_dec = (remaining_reg != '0) ? remaining_reg - 1'b1 : remaining_reg;
    assign orphan        = (item_mode_reg == sbpf_pkg::MODE_PARAM) && !packet_open_reg;
    assign open_now      = (item_mode_reg == sbpf_pkg::MODE_START)
                           && (step_reg == sbpf_pkg::STEP_INSTR);

    // Byte selection for the current sequencer step.
    always_comb begin
        byte_val  = 8'h00;
        is_data   = 1'b0;
        is_crc_hi = 1'b0;
        byte_last = 1'b0;
        byte_err  = 1'b0;
        if (item_mode_reg == sbpf_pkg::MODE_START) begin
            if (step_reg == sbpf_pkg::STEP_HDR_CRCL) begin
                byte_val = crc_reg[7:0];
            end else if (step_reg == sbpf_pkg::STEP_HDR_CRCH) begin
                byte_val  = crc_reg[15:8];
                is_crc_hi = 1'b1;
                byte_last = 1'b1;
            end else begin
                is_data = 1'b1;
                unique case (sbpf_pkg::hdr_pos_t'(step_reg[2:0]))
                    sbpf_pkg::HDR_SYNC0: byte_val = sbpf_pkg::HDR_SYNC;
                    sbpf_pkg::HDR_SYNC1: byte_val = sbpf_pkg::HDR_SYNC;
                    sbpf_pkg::HDR_MARKB: byte_val = sbpf_pkg::HDR_MARK;
                    sbpf_pkg::HDR_RSVD:  byte_val = sbpf_pkg::HDR_RESERVED;
                    sbpf_pkg::HDR_ID:    byte_val = item_id_reg;
                    sbpf_pkg::HDR_LENL:  byte_val = pkt_len[7:0];
                    sbpf_pkg::HDR_LENH:  byte_val = {{(16-sbpf_pkg::COUNT_W){1'b0}},
                                                     pkt_len[sbpf_pkg::COUNT_W-1:8]};
                    sbpf_pkg::HDR_INSTR: byte_val = item_instr_reg;
                    default:             byte_val = 8'h00;
                endcase
                // A restart while a packet is open is flagged on the first header byte.
                byte_err  = (step_reg == sbpf_pkg::STEP_FIRST) && packet_open_reg;
                byte_last = (step_reg == sbpf_pkg::STEP_INSTR) && (sat_count != '0);
            end
        end else if (orphan) begin
            byte_err  = 1'b1;
            byte_last = 1'b1;
        end else begin
            if (step_reg == sbpf_pkg::STEP_PRM_CRCL) begin
                byte_val = crc_reg[7:0];
            end else if (step_reg == sbpf_pkg::STEP_PRM_CRCH) begin
                byte_val  = crc_reg[15:8];
                is_crc_hi = 1'b1;
                byte_last = 1'b1;
            end else begin
                byte_val  = item_param_reg;
                is_data   = 1'b1;
                byte_last = (remaining_dec != '0);
            end
        end
        byte_end = is_crc_hi;
    end

    assign crc_base = ((item_mode_reg == sbpf_pkg::MODE_START)
                       && (step_reg == sbpf_pkg::STEP_FIRST)) ? 16'h0000 : crc_reg;
    assign crc_upd  = sbpf_pkg::crc_byte(crc_base, byte_val);

    assign out_load = item_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !item_valid_reg || (out_load && byte_last);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg  <= 1'b0;
            step_reg        <= '0;
            packet_open_reg <= 1'b0;
            remaining_reg   <= '0;
            crc_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                item_valid_reg <= 1'b1;
            end else if (out_load && byte_last) begin
                item_valid_reg <= 1'b0;
            end

            if (out_load) begin
                step_reg <= byte_last ? '0 : step_reg + 1'b1;
                if (is_data) begin
                    crc_reg <= crc_upd;
                end
                if (open_now) begin
                    packet_open_reg <= 1'b1;
                    remaining_reg   <= sat_count;
                end else if (is_data && (item_mode_reg == sbpf_pkg::MODE_PARAM)) begin
                    remaining_reg <= remaining_dec;
                end
                if (is_crc_hi) begin
                    packet_open_reg <= 1'b0;
                    remaining_reg   <= '0;
                    crc_reg         <= '0;
                end
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_mode_reg  <= sbpf_pkg::mode_t'(s_tuser);
            item_id_reg    <= s_tdata[7:0];
            item_instr_reg <= s_tdata[15:8];
            item_count_reg <= s_tdata[26:16];
            item_param_reg <= s_tdata[34:27];
        end
        if (out_load) begin
            m_tdata_reg <= byte_val;
            m_tlast_reg <= byte_last;
            m_tuser_reg <= {byte_err, byte_end};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg |-> (step_reg <= sbpf_pkg::STEP_HDR_CRCH))
        else $error("sequencer step out of range");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("packet end without last of run");

    a_err_not_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> !m_tuser[0])
        else $error("error flag on a closing CRC byte");

    a_open_expects: assert property (@(posedge aclk) disable iff (!aresetn)
        (packet_open_reg && !item_valid_reg) |-> (remaining_reg != '0))
        else $error("open packet expects no parameters");
`endif

endmodule

`default_nettype wire
